@@ hdl/lome_pkg.sv @@
// Shared definitions for the linked order move engine.
// Field widths, command codes and status codes; no dependencies.
package lome_pkg;

    localparam int ENTRY_W             = 16;
    localparam int CMD_W               = 2;
    localparam int DEFAULT_MAX_ENTRIES = 65535;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT   = 2'd0,
        CMD_BEFORE = 2'd1,
        CMD_AFTER  = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

endpackage

@@ hdl/lome_if.sv @@
// Valid/ready channel interfaces for command items and result items.
// Depends on lome_pkg for field widths.
interface lome_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [lome_pkg::CMD_W-1:0]     cmd;
    logic [lome_pkg::ENTRY_W-1:0]   entry_x;
    logic [lome_pkg::ENTRY_W-1:0]   entry_y;

    modport source (output valid, cmd, entry_x, entry_y, input ready);
    modport sink   (input valid, cmd, entry_x, entry_y, output ready);
endinterface

interface lome_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           status;
    logic [lome_pkg::ENTRY_W-1:0]   next_entry;
    logic [lome_pkg::ENTRY_W-1:0]   prev_entry;

    modport source (output valid, status, next_entry, prev_entry, input ready);
    modport sink   (input valid, status, next_entry, prev_entry, output ready);
endinterface

@@ hdl/lome_link_ram.sv @@
// One link table: single write port, two registered read ports.
// Contents are undefined until written. Depends on nothing.
module lome_link_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hdl/lome_ctrl.sv @@
// Command sequencer: init sweep, link read, unlink/relink writes, result register.
// Depends on lome_pkg and the channel interfaces in lome_if.
module lome_ctrl #(
    parameter int MAX_ENTRIES = lome_pkg::DEFAULT_MAX_ENTRIES,
    parameter int AW          = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lome_cmd_if.sink                     req,
    lome_rsp_if.source                   rsp,
    input  logic [lome_pkg::ENTRY_W-1:0] count_clip,
    output logic                         s_we,
    output logic [AW-1:0]                s_waddr,
    output logic [lome_pkg::ENTRY_W-1:0] s_wdata,
    output logic                         p_we,
    output logic [AW-1:0]                p_waddr,
    output logic [lome_pkg::ENTRY_W-1:0] p_wdata,
    output logic [AW-1:0]                raddr_x,
    output logic [AW-1:0]                raddr_y,
    input  logic [lome_pkg::ENTRY_W-1:0] s_rd_x,
    input  logic [lome_pkg::ENTRY_W-1:0] s_rd_y,
    input  logic [lome_pkg::ENTRY_W-1:0] p_rd_x,
    input  logic [lome_pkg::ENTRY_W-1:0] p_rd_y
);
    import lome_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_READ,
        S_UNLINK,
        S_LINK,
        S_SELF,
        S_DONE
    } state_t;

    typedef logic [ENTRY_W-1:0] entry_t;

    state_t state_reg,  state_next;
    cmd_t   cmd_reg,    cmd_next;
    entry_t x_reg,      x_next;
    entry_t y_reg,      y_next;
    entry_t active_reg, active_next;
    entry_t sweep_reg,  sweep_next;
    entry_t sx_reg,     sx_next;
    entry_t px_reg,     px_next;
    entry_t left_reg,   left_next;
    entry_t right_reg,  right_next;
    logic   res_status_reg, res_status_next;
    entry_t res_next_reg,   res_next_next;
    entry_t res_prev_reg,   res_prev_next;
    logic   out_valid_reg,  out_valid_next;
    logic   out_status_reg, out_status_next;
    entry_t out_next_reg,   out_next_next;
    entry_t out_prev_reg,   out_prev_next;

    logic   accept;
    logic   x_in_range;
    logic   move_ok;
    logic   is_move;
    logic   out_free;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.next_entry = out_next_reg;
    assign rsp.prev_entry = out_prev_reg;

    // Reads are issued from the incoming item; data is used in S_READ only.
    assign raddr_x = AW'(req.entry_x);
    assign raddr_y = AW'(req.entry_y);

    assign x_in_range = (x_reg <= active_reg);
    assign is_move    = (cmd_reg == CMD_BEFORE) || (cmd_reg == CMD_AFTER);
    assign move_ok    = (x_reg != '0) && (y_reg != '0) && x_in_range
                        && (y_reg <= active_reg) && (x_reg != y_reg);

    // Link table writes
    always_comb
    begin
        s_we    = 1'b0;
        p_we    = 1'b0;
        s_waddr = AW'(x_reg);
        p_waddr = AW'(x_reg);
        s_wdata = right_reg;
        p_wdata = left_reg;
        unique case (state_reg)
            S_INIT:
            begin
                s_we    = 1'b1;
                p_we    = 1'b1;
                s_waddr = AW'(sweep_reg);
                p_waddr = AW'(sweep_reg);
                s_wdata = (sweep_reg == active_reg) ? '0 : entry_t'(sweep_reg + 1'b1);
                p_wdata = (sweep_reg == '0) ? active_reg : entry_t'(sweep_reg - 1'b1);
            end
            S_UNLINK:
            begin
                s_we    = 1'b1;
                p_we    = 1'b1;
                s_waddr = AW'(px_reg);
                s_wdata = sx_reg;
                p_waddr = AW'(sx_reg);
                p_wdata = px_reg;
            end
            S_LINK:
            begin
                s_we    = 1'b1;
                p_we    = 1'b1;
                s_waddr = AW'(left_reg);
                s_wdata = x_reg;
                p_waddr = AW'(right_reg);
                p_wdata = x_reg;
            end
            S_SELF:
            begin
                s_we = 1'b1;
                p_we = 1'b1;
            end
            default:
            begin
                s_we = 1'b0;
                p_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        active_next     = active_reg;
        sweep_next      = sweep_reg;
        sx_next         = sx_reg;
        px_next         = px_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        res_status_next = res_status_reg;
        res_next_next   = res_next_reg;
        res_prev_next   = res_prev_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_next_next   = out_next_reg;
        out_prev_next   = out_prev_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd_t'(req.cmd);
                    x_next   = req.entry_x;
                    y_next   = req.entry_y;
                    if (cmd_t'(req.cmd) == CMD_INIT)
                    begin
                        active_next = count_clip;
                        sweep_next  = '0;
                        state_next  = S_INIT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_INIT:
            begin
                sweep_next = entry_t'(sweep_reg + 1'b1);
                if (sweep_reg == active_reg)
                begin
                    res_status_next = STATUS_OK;
                    if (x_in_range)
                    begin
                        res_next_next = (x_reg == active_reg) ? '0 : entry_t'(x_reg + 1'b1);
                        res_prev_next = (x_reg == '0) ? active_reg : entry_t'(x_reg - 1'b1);
                    end
                    else
                    begin
                        res_next_next = '0;
                        res_prev_next = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                sx_next = s_rd_x;
                px_next = p_rd_x;
                if (cmd_reg == CMD_BEFORE)
                begin
                    right_next = y_reg;
                    left_next  = (y_reg == s_rd_x) ? p_rd_x : p_rd_y;
                end
                else
                begin
                    left_next  = y_reg;
                    right_next = (y_reg == p_rd_x) ? s_rd_x : s_rd_y;
                end
                if (is_move && move_ok)
                begin
                    state_next = S_UNLINK;
                end
                else
                begin
                    res_status_next = (is_move || !x_in_range) ? STATUS_REJECT : STATUS_OK;
                    res_next_next   = x_in_range ? s_rd_x : '0;
                    res_prev_next   = x_in_range ? p_rd_x : '0;
                    state_next      = S_DONE;
                end
            end
            S_UNLINK:
            begin
                state_next = S_LINK;
            end
            S_LINK:
            begin
                state_next = S_SELF;
            end
            S_SELF:
            begin
                res_status_next = STATUS_OK;
                res_next_next   = right_reg;
                res_prev_next   = left_reg;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_next_next   = res_next_reg;
                    out_prev_next   = res_prev_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        sweep_reg      <= sweep_next;
        sx_reg         <= sx_next;
        px_reg         <= px_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        res_status_reg <= res_status_next;
        res_next_reg   <= res_next_next;
        res_prev_reg   <= res_prev_next;
        out_status_reg <= out_status_next;
        out_next_reg   <= out_next_next;
        out_prev_reg   <= out_prev_next;
    end

`ifndef SYNTHESIS
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_reg) <= 32'(MAX_ENTRIES))
        else $error("active count above table size");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> (sweep_reg <= active_reg))
        else $error("init sweep ran past active count");

    a_self_links: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SELF) |-> (left_reg != x_reg && right_reg != x_reg))
        else $error("moved entry linked to itself");

    a_move_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UNLINK) |-> (is_move && $past(state_reg) == S_READ))
        else $error("unlink without a checked move");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result loaded outside done state");
`endif

endmodule

@@ hdl/linked_order_move_engine_top.sv @@
// Top level of the linked order move engine: entry count register, link tables
// and command sequencer. Depends on lome_pkg, lome_if, lome_link_ram, lome_ctrl.
//
// Usage:
//   req carries one command item (cmd, entry_x, entry_y) per valid/ready
//   handshake; rsp returns exactly one result item (status, next_entry,
//   prev_entry) for each command, in order.
//   cfg_we/cfg_wdata write entry_count, which the next init command uses;
//   counts above MAX_ENTRIES are clipped.
//   The block takes one command at a time and drops ready while it works.
//   Steps from accept to result valid:
//     query or rejected move: registered link read, result stage;
//     accepted move: read, unlink, relink, self-link writes, result stage;
//     init: sweep over entries 0 to count, one entry of both link tables written per cycle.
//   Both link tables share one write port each, which sets the move latency.
//   A finished result sits in an output register, so the next command is
//   accepted while rsp is stalled; a second result then waits in the
//   sequencer until the output register frees.
//   Reset empties the list (active count 0, so moves are rejected until an
//   init) and sets entry_count to 1; link tables are not cleared.
module linked_order_move_engine_top #(
    parameter int MAX_ENTRIES = lome_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lome_cmd_if.sink                     req,
    lome_rsp_if.source                   rsp,
    input  logic                         cfg_we,
    input  logic [lome_pkg::ENTRY_W-1:0] cfg_wdata
);
    import lome_pkg::*;

    localparam int DEPTH = MAX_ENTRIES + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [ENTRY_W-1:0] entry_count_reg;
    logic [ENTRY_W-1:0] count_clip;

    logic               s_we;
    logic [AW-1:0]      s_waddr;
    logic [ENTRY_W-1:0] s_wdata;
    logic               p_we;
    logic [AW-1:0]      p_waddr;
    logic [ENTRY_W-1:0] p_wdata;
    logic [AW-1:0]      raddr_x;
    logic [AW-1:0]      raddr_y;
    logic [ENTRY_W-1:0] s_rd_x;
    logic [ENTRY_W-1:0] s_rd_y;
    logic [ENTRY_W-1:0] p_rd_x;
    logic [ENTRY_W-1:0] p_rd_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_W'(1);
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (32'(entry_count_reg) > 32'(MAX_ENTRIES))
        begin
            count_clip = ENTRY_W'(MAX_ENTRIES);
        end
        else
        begin
            count_clip = entry_count_reg;
        end
    end

    lome_link_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (ENTRY_W)
    ) u_succ_ram (
        .clk     (clk),
        .we      (s_we),
        .waddr   (s_waddr),
        .wdata   (s_wdata),
        .raddr_a (raddr_x),
        .raddr_b (raddr_y),
        .rdata_a (s_rd_x),
        .rdata_b (s_rd_y)
    );

    lome_link_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (ENTRY_W)
    ) u_pred_ram (
        .clk     (clk),
        .we      (p_we),
        .waddr   (p_waddr),
        .wdata   (p_wdata),
        .raddr_a (raddr_x),
        .raddr_b (raddr_y),
        .rdata_a (p_rd_x),
        .rdata_b (p_rd_y)
    );

    lome_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .count_clip (count_clip),
        .s_we       (s_we),
        .s_waddr    (s_waddr),
        .s_wdata    (s_wdata),
        .p_we       (p_we),
        .p_waddr    (p_waddr),
        .p_wdata    (p_wdata),
        .raddr_x    (raddr_x),
        .raddr_y    (raddr_y),
        .s_rd_x     (s_rd_x),
        .s_rd_y     (s_rd_y),
        .p_rd_x     (p_rd_x),
        .p_rd_y     (p_rd_y)
    );

endmodule
